// ----- hw/rtl/dxt1_pkg.sv -----
// Shared types, constants and helper functions for the DXT1 sub-block decoder.
// Depends on nothing; every other file of the block imports it.
package dxt1_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Field masks of an RGB565 color.
    localparam logic [15:0] MASK_R = 16'hF800;
    localparam logic [15:0] MASK_G = 16'h07E0;
    localparam logic [15:0] MASK_B = 16'h001F;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
    localparam logic [7:0] ALPHA_CLEAR  = 8'h00;

    // Reciprocal of three in 11 fractional bits; exact for sums up to 765.
    localparam logic [9:0] RECIP3     = 10'd683;
    localparam int         RECIP3_SHR = 11;

    localparam logic [1:0] LAST_ROW_NUM = 2'd3;

    typedef logic [31:0] pixel_t;

    // One decoded sub-block waiting for the row emitter.
    typedef struct packed {
        pixel_t [3:0] palette;
        logic [31:0]  index_bits;
    } dxt1_entry_t;

    // Queue status seen by the back end and the top level.
    typedef struct packed {
        logic full;
        logic empty;
    } dxt1_qstat_t;

    // Divide a blend sum of at most 765 by three.
    function automatic logic [7:0] div3(input logic [9:0] v);
        logic [19:0] prod;
        begin
            prod = v * RECIP3;
            div3 = prod[RECIP3_SHR +: 8];
        end
    endfunction

    // Expand RGB565 to RGBA8 by plain left shifts, alpha opaque.
    function automatic pixel_t expand565(input logic [15:0] c);
        logic [15:0] r;
        logic [15:0] g;
        logic [15:0] b;
        begin
            r = c & MASK_R;
            g = c & MASK_G;
            b = c & MASK_B;
            expand565 = {r[15:11], 3'b000, g[10:5], 2'b00, b[4:0], 3'b000,
                         ALPHA_OPAQUE};
        end
    endfunction

endpackage

// ----- hw/rtl/dxt1_front.sv -----
// Front end: expands the endpoints and builds the four-entry palette.
// Depends on dxt1_pkg.
module dxt1_front
    import dxt1_pkg::*;
(
    input  logic [15:0] color_a,
    input  logic [15:0] color_b,
    input  logic [31:0] index_bits,
    output dxt1_entry_t entry
);

    pixel_t     pa;
    pixel_t     pb;
    logic       four_color;
    pixel_t     pal2;
    pixel_t     pal3;

    assign pa         = expand565(color_a);
    assign pb         = expand565(color_b);
    assign four_color = color_a > color_b;

    always_comb
    begin
        logic [9:0] ca;
        logic [9:0] cb;
        pal2 = '0;
        pal3 = '0;
        for (int ch = 1; ch < 4; ch++) begin
            ca = {2'b00, pa[ch*8 +: 8]};
            cb = {2'b00, pb[ch*8 +: 8]};
            if (four_color) begin
                pal2[ch*8 +: 8] = div3((ca << 1) + cb);
            end else begin
                pal2[ch*8 +: 8] = 8'((ca + cb) >> 1);
            end
            pal3[ch*8 +: 8] = div3(ca + (cb << 1));
        end
        pal2[7:0] = ALPHA_OPAQUE;
        pal3[7:0] = four_color ? ALPHA_OPAQUE : ALPHA_CLEAR;
    end

    assign entry.palette    = {pal3, pal2, pb, pa};
    assign entry.index_bits = index_bits;

endmodule

// ----- hw/rtl/dxt1_queue.sv -----
// Short queue of decoded sub-blocks between the front and back ends.
// Depends on dxt1_pkg.
module dxt1_queue
    import dxt1_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  dxt1_entry_t push_entry,
    input  logic        pop,
    output dxt1_entry_t head,
    output dxt1_qstat_t stat
);

    dxt1_entry_t             slots_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]       wr_ptr_reg;
    logic [QPTR_W-1:0]       rd_ptr_reg;
    logic [QCNT_W-1:0]       count_reg;
    logic [QCNT_W-1:0]       count_next;

    always_ff @(posedge clk)
    begin
        if (push) begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    assign head       = slots_reg[rd_ptr_reg];
    assign stat.full  = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign stat.empty = count_reg == '0;

endmodule

// ----- hw/rtl/dxt1_back.sv -----
// Back end: while the queue holds an item, registers one head row per cycle.
// Depends on dxt1_pkg.
module dxt1_back
    import dxt1_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  dxt1_entry_t head,
    input  dxt1_qstat_t stat,
    output logic        pop,
    output logic        result_valid,
    output pixel_t      pixel_left,
    output pixel_t      pixel_mid_left,
    output pixel_t      pixel_mid_right,
    output pixel_t      pixel_right,
    output logic [1:0]  row_number,
    output logic        last_row
);

    logic [1:0]   row_reg;
    logic         valid_reg;
    pixel_t [3:0] pix_reg;
    pixel_t [3:0] pix_next;
    logic [1:0]   row_out_reg;
    logic         last_reg;
    logic [7:0]   row_bits;

    // Row 0 uses the top byte of the index word.
    always_comb
    begin
        case (row_reg)
            2'd0:    row_bits = head.index_bits[31:24];
            2'd1:    row_bits = head.index_bits[23:16];
            2'd2:    row_bits = head.index_bits[15:8];
            default: row_bits = head.index_bits[7:0];
        endcase
        for (int c = 0; c < 4; c++) begin
            pix_next[c] = head.palette[row_bits[7 - 2*c -: 2]];
        end
    end

    assign pop = !stat.empty && (row_reg == LAST_ROW_NUM);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            row_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= !stat.empty;
            if (!stat.empty) begin
                row_reg <= row_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!stat.empty) begin
            pix_reg     <= pix_next;
            row_out_reg <= row_reg;
            last_reg    <= row_reg == LAST_ROW_NUM;
        end
    end

    assign result_valid    = valid_reg;
    assign pixel_left      = pix_reg[0];
    assign pixel_mid_left  = pix_reg[1];
    assign pixel_mid_right = pix_reg[2];
    assign pixel_right     = pix_reg[3];
    assign row_number      = row_out_reg;
    assign last_row        = last_reg;

endmodule

// ----- hw/rtl/dxt1_subblock_decoder.sv -----
// DXT1 sub-block decoder top level: one 4x4 sub-block in, four row results out.
// An item taken into an empty queue is written to a slot, and its first row is then
// registered in the back end. Rows go out one per cycle while an item is queued;
// a new item can be taken before the last is done. Asynchronous active-low reset
// empties the queue and clears the strobe; the receiver cannot stall the results.
// Depends on dxt1_pkg, dxt1_front, dxt1_queue and dxt1_back.
module dxt1_subblock_decoder
    import dxt1_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] color_a,
    input  logic [15:0] color_b,
    input  logic [31:0] index_bits,
    output logic        result_valid,
    output logic [31:0] pixel_left,
    output logic [31:0] pixel_mid_left,
    output logic [31:0] pixel_mid_right,
    output logic [31:0] pixel_right,
    output logic [1:0]  row_number,
    output logic        last_row
);

    // The front end builds the full palette in the accept cycle, so the queue
    // holds a ready-to-emit sub-block and the back end only selects per pixel.
    dxt1_entry_t front_entry;
    dxt1_entry_t head;
    dxt1_qstat_t stat;
    logic        push;
    logic        pop;

    // An item is taken whenever the queue has a free slot; with two slots the
    // front can take the next sub-block while the back end still emits rows.
    assign busy = stat.full;
    assign push = start && !busy;

    dxt1_front u_front (
        .color_a    (color_a),
        .color_b    (color_b),
        .index_bits (index_bits),
        .entry      (front_entry)
    );

    dxt1_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (front_entry),
        .pop        (pop),
        .head       (head),
        .stat       (stat)
    );

    // The back end sends rows 0 to 3 on consecutive cycles and frees the slot
    // together with the last row.
    dxt1_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .head            (head),
        .stat            (stat),
        .pop             (pop),
        .result_valid    (result_valid),
        .pixel_left      (pixel_left),
        .pixel_mid_left  (pixel_mid_left),
        .pixel_mid_right (pixel_mid_right),
        .pixel_right     (pixel_right),
        .row_number      (row_number),
        .last_row        (last_row)
    );

    // Rows after the first follow their predecessor directly.
    a_rows_consecutive: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && row_number != 2'd0 |->
            $past(result_valid) && $past(row_number) == row_number - 2'd1)
        else $error("row result without its preceding row");

    // An item taken into an empty queue passes the queue slot and the back-end row
    // registers, and is then strobed as row 0.
    a_empty_accept: assert property (@(posedge clk) disable iff (!rst_n)
        push && stat.empty |-> ##2 (result_valid && row_number == 2'd0))
        else $error("accepted item did not start at row 0");

    // The last-row mark goes only with the fourth row.
    a_last_mark: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> last_row == (row_number == LAST_ROW_NUM))
        else $error("last_row mark out of step with row_number");

    // A slot is freed only while rows are being emitted.
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !stat.empty)
        else $error("queue popped while empty");

endmodule

// ----- dv/tb_dxt1_subblock_decoder.sv -----
// Self-checking testbench for the DXT1 sub-block decoder: directed and random sub-blocks,
// predicted rows compared field by field against the four row results of each item.
// Depends on dxt1_pkg and dxt1_subblock_decoder; reads no files.
`timescale 1ns / 1ps

module tb_dxt1_subblock_decoder;
    import dxt1_pkg::*;

    // One decoded row as the block should present it on the result ports.
    typedef struct {
        pixel_t     left;
        pixel_t     mid_left;
        pixel_t     mid_right;
        pixel_t     right;
        logic [1:0] row;
        logic       last;
    } row_item_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic [15:0] color_a = '0;
    logic [15:0] color_b = '0;
    logic [31:0] index_bits = '0;
    logic        busy;
    logic        result_valid;
    logic [31:0] pixel_left;
    logic [31:0] pixel_mid_left;
    logic [31:0] pixel_mid_right;
    logic [31:0] pixel_right;
    logic [1:0]  row_number;
    logic        last_row;

    // Rows predicted for accepted items, oldest first.
    row_item_t pending_rows[$];
    int        fail_count = 0;

    dxt1_subblock_decoder DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .color_a        (color_a),
        .color_b        (color_b),
        .index_bits     (index_bits),
        .result_valid   (result_valid),
        .pixel_left     (pixel_left),
        .pixel_mid_left (pixel_mid_left),
        .pixel_mid_right(pixel_mid_right),
        .pixel_right    (pixel_right),
        .row_number     (row_number),
        .last_row       (last_row)
    );

    always #5 clk = ~clk;

    // Widen an RGB565 endpoint to RGBA8. The low bits are left as zero rather than
    // replicated, and the endpoints themselves are always opaque.
    function automatic pixel_t widen_565(input logic [15:0] c);
        pixel_t px;
        begin
            px = {c[15:11], 3'b000, c[10:5], 2'b00, c[4:0], 3'b000, ALPHA_OPAQUE};
            return px;
        end
    endfunction

    // Weighted blend of the R, G and B channels, truncated by the integer divide.
    // The largest possible sum is 3 * 255, so no channel ever overflows 8 bits.
    function automatic pixel_t blend_channels(input pixel_t a, input pixel_t b,
                                              input int wa, input int wb,
                                              input int divisor, input logic [7:0] alpha);
        pixel_t px;
        int     sum;
        begin
            px = '0;
            px[7:0] = alpha;
            for (int sh = 8; sh <= 24; sh += 8)
            begin
                sum = (wa * int'(a[sh +: 8]) + wb * int'(b[sh +: 8])) / divisor;
                px[sh +: 8] = sum[7:0];
            end
            return px;
        end
    endfunction

    // Build the four-entry palette for an item and queue the four rows it produces.
    // color_a > color_b selects the four-color mode; equal endpoints fall into the
    // three-color mode, where the last entry is the transparent one.
    task automatic decode_subblock(input logic [15:0] ca, input logic [15:0] cb,
                                   input logic [31:0] bits);
        pixel_t    palette[4];
        pixel_t    px[4];
        row_item_t r;
        int        p;
        begin
            palette[0] = widen_565(ca);
            palette[1] = widen_565(cb);
            if (ca > cb)
            begin
                palette[2] = blend_channels(palette[0], palette[1], 2, 1, 3, ALPHA_OPAQUE);
                palette[3] = blend_channels(palette[0], palette[1], 1, 2, 3, ALPHA_OPAQUE);
            end
            else
            begin
                palette[2] = blend_channels(palette[0], palette[1], 1, 1, 2, ALPHA_OPAQUE);
                palette[3] = blend_channels(palette[0], palette[1], 1, 2, 3, ALPHA_CLEAR);
            end
            for (int row = 0; row < 4; row++)
            begin
                // Pixel 0 owns the two most significant index bits.
                for (int col = 0; col < 4; col++)
                begin
                    p = row * 4 + col;
                    px[col] = palette[bits[(15 - p) * 2 +: 2]];
                end
                r.left      = px[0];
                r.mid_left  = px[1];
                r.mid_right = px[2];
                r.right     = px[3];
                r.row       = row[1:0];
                r.last      = (row[1:0] == LAST_ROW_NUM);
                pending_rows = {pending_rows, r};
            end
        end
    endtask

    // Present one item and hold it until the block takes it. An item is taken at
    // the edge where start is high and busy was low. The task must be called just
    // after a rising edge, and it leaves start high so that the next item can
    // follow directly; dropping start is left to the idle and drain tasks.
    task automatic issue_subblock(input logic [15:0] ca, input logic [15:0] cb,
                                  input logic [31:0] bits);
        bit taken;
        begin
            start      <= 1'b1;
            color_a    <= ca;
            color_b    <= cb;
            index_bits <= bits;
            taken = 1'b0;
            while (!taken)
            begin
                @(posedge clk);
                taken = !busy;
            end
            decode_subblock(ca, cb, bits);
        end
    endtask

    // Drop start for an idle burst of random length.
    task automatic idle_sender();
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
    endtask

    // Stop sending and wait until every predicted row has been seen or a guard runs out.
    // A clock edge always passes, so start never gets two assignments in one step.
    task automatic drain_rows();
        int guard;
        begin
            start <= 1'b0;
            @(posedge clk);
            guard = 0;
            while (pending_rows.size() != 0 && guard < 2000)
            begin
                @(posedge clk);
                guard++;
            end
        end
    endtask

    // Random endpoints that hit both palette modes, including equal endpoints and
    // neighbors one to three apart, which sit near the mode boundary.
    task automatic random_subblock(output logic [15:0] ca, output logic [15:0] cb,
                                   output logic [31:0] bits);
        logic [15:0] delta;
        begin
            ca   = 16'($urandom);
            bits = $urandom;
            case ($urandom_range(0, 5))
                0: cb = ca;
                1:
                begin
                    delta = 16'($urandom_range(1, 3));
                    cb = ca + delta;
                end
                2:
                begin
                    delta = 16'($urandom_range(1, 3));
                    cb = ca - delta;
                end
                default: cb = 16'($urandom);
            endcase
        end
    endtask

    // Edge values of every field, both palette modes, each index value in every
    // column, and channel values that make the divide by three truncate.
    task automatic test_directed();
        begin
            issue_subblock(16'h0000, 16'h0000, 32'h0000_0000);
            issue_subblock(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
            issue_subblock(16'hFFFF, 16'h0000, 32'hE4E4_E4E4);
            issue_subblock(16'h0000, 16'hFFFF, 32'h1B1B_1B1B);
            issue_subblock(16'hF800, 16'h07E0, 32'h5555_5555);
            issue_subblock(16'h07E0, 16'hF800, 32'hAAAA_AAAA);
            issue_subblock(16'h001F, 16'h0000, 32'h39C6_39C6);
            issue_subblock(16'h0000, 16'h001F, 32'hC639_C639);
            issue_subblock(16'h8001, 16'h8000, 32'h0123_4567);
            issue_subblock(16'h8000, 16'h8001, 32'h89AB_CDEF);
            issue_subblock(16'h1234, 16'h1234, 32'hFEDC_BA98);
            idle_sender();
            issue_subblock(16'h0841, 16'h0000, 32'hFFFF_0000);
            issue_subblock(16'h0000, 16'h0841, 32'h0000_FFFF);
            issue_subblock(16'hFFFF, 16'hFFFE, 32'hF0F0_0F0F);
            issue_subblock(16'hFFFE, 16'hFFFF, 32'h0F0F_F0F0);
            issue_subblock(16'h7BEF, 16'h8410, 32'hFFFF_FFFF);
            issue_subblock(16'h8410, 16'h7BEF, 32'hFFFF_FFFF);
        end
    endtask

    // Random items with random idle bursts between them.
    task automatic test_random_gaps(input int count);
        logic [15:0] ca;
        logic [15:0] cb;
        logic [31:0] bits;
        begin
            repeat (count)
            begin
                random_subblock(ca, cb, bits);
                issue_subblock(ca, cb, bits);
                if ($urandom_range(0, 2) == 0)
                    idle_sender();
            end
        end
    endtask

    // Small groups of items, each followed by a full drain of the block, so that
    // items also land on an empty block after a long quiet stretch.
    task automatic test_drain_pauses(input int groups);
        logic [15:0] ca;
        logic [15:0] cb;
        logic [31:0] bits;
        begin
            repeat (groups)
            begin
                repeat ($urandom_range(1, 4))
                begin
                    random_subblock(ca, cb, bits);
                    issue_subblock(ca, cb, bits);
                end
                drain_rows();
            end
        end
    endtask

    // Back-to-back items with start held high, the block at full rate.
    task automatic test_back_to_back(input int count);
        logic [15:0] ca;
        logic [15:0] cb;
        logic [31:0] bits;
        begin
            repeat (count)
            begin
                random_subblock(ca, cb, bits);
                issue_subblock(ca, cb, bits);
            end
        end
    endtask

    // Every strobed row is checked against the oldest prediction. The receiver
    // cannot stall, so a row is taken on every edge that ends a strobed cycle.
    always @(posedge clk)
    begin
        row_item_t exp_row;
        if (rst_n && result_valid)
        begin
            if (pending_rows.size() == 0)
            begin
                $error("row %0d arrived with no item outstanding", row_number);
                fail_count++;
            end
            else
            begin
                exp_row = pending_rows.pop_front();
                if (pixel_left !== exp_row.left)
                begin
                    $error("pixel_left: expected %08h, got %08h", exp_row.left, pixel_left);
                    fail_count++;
                end
                if (pixel_mid_left !== exp_row.mid_left)
                begin
                    $error("pixel_mid_left: expected %08h, got %08h",
                           exp_row.mid_left, pixel_mid_left);
                    fail_count++;
                end
                if (pixel_mid_right !== exp_row.mid_right)
                begin
                    $error("pixel_mid_right: expected %08h, got %08h",
                           exp_row.mid_right, pixel_mid_right);
                    fail_count++;
                end
                if (pixel_right !== exp_row.right)
                begin
                    $error("pixel_right: expected %08h, got %08h", exp_row.right, pixel_right);
                    fail_count++;
                end
                if (row_number !== exp_row.row)
                begin
                    $error("row_number: expected %0d, got %0d", exp_row.row, row_number);
                    fail_count++;
                end
                if (last_row !== exp_row.last)
                begin
                    $error("last_row: expected %0b, got %0b", exp_row.last, last_row);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_gaps(200);
        test_drain_pauses(20);
        test_random_gaps(60);
        // The closing stretch runs without any idling at all.
        test_back_to_back(140);

        drain_rows();
        if (pending_rows.size() != 0)
        begin
            $error("%0d predicted rows never arrived", pending_rows.size());
            fail_count += pending_rows.size();
        end
        // The bench waits on so that a stray extra row would still be caught.
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Safety net: the slowest legal run needs well under a tenth of this.
    initial
    begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
